// ===== hdl/bfpcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpcrc_pkg
// Shared types, constants and the CRC-16 bit step of the bit field packer.
// ----------------------------------------------------------------------------
package bfpcrc_pkg;

  localparam int MAX_FIELD_BITS_DEF = 64;
  localparam int FIELD_WIDTH_W      = 7;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QUEUE_PTR_W        = 1;
  localparam int QUEUE_CNT_W        = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Classified field as it waits in the queue
  typedef struct packed {
    logic [FIELD_WIDTH_W-1:0] width;   // already clamped to the maximum
    logic                     eof;
  } field_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIELD,
    ST_CRC,
    ST_FLUSH
  } back_state_t;

  // Back end status, watched by the top level checks
  typedef struct packed {
    back_state_t state;
    logic [2:0]  fill;
    logic        crc_init;
    logic        adv;
    logic        load;
  } back_status_t;

  // One bit of CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic data_bit);
    logic [15:0] c;
    c = crc ^ {data_bit, 15'b0};
    if ((c & CRC_TOP) != 16'h0000) begin
      crc_step = {c[14:0], 1'b0} ^ CRC_POLY;
    end else begin
      crc_step = {c[14:0], 1'b0};
    end
  endfunction

endpackage

// ===== hdl/bfpcrc_front.sv =====
// ----------------------------------------------------------------------------
// bfpcrc_front
// Accepts fields, clamps the width and holds them in a two entry queue.
// ----------------------------------------------------------------------------
module bfpcrc_front import bfpcrc_pkg::*; #(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [63:0]               field_value,
  input  logic [FIELD_WIDTH_W-1:0]  field_width,
  input  logic                      end_of_frame,
  output logic                      q_valid,
  output logic [MAX_FIELD_BITS-1:0] q_value,
  output field_ctrl_t               q_ctrl,
  input  logic                      q_pop
);

  logic [MAX_FIELD_BITS-1:0] value_mem [QUEUE_DEPTH];
  field_ctrl_t               ctrl_mem  [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]    wr_ptr;
  logic [QUEUE_PTR_W-1:0]    rd_ptr;
  logic [QUEUE_CNT_W-1:0]    count;
  logic                      push;
  field_ctrl_t               ctrl_in;

  // Clamp oversize widths
  always_comb begin
    if (field_width > FIELD_WIDTH_W'(MAX_FIELD_BITS)) begin
      ctrl_in.width = FIELD_WIDTH_W'(MAX_FIELD_BITS);
    end else begin
      ctrl_in.width = field_width;
    end
    ctrl_in.eof = end_of_frame;
  end

  assign in_stall = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_value  = value_mem[rd_ptr];
  assign q_ctrl   = ctrl_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      value_mem[wr_ptr] <= field_value[MAX_FIELD_BITS-1:0];
      ctrl_mem[wr_ptr]  <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/bfpcrc_back.sv =====
// ----------------------------------------------------------------------------
// bfpcrc_back
// Bit-serial packer and CRC engine with a registered byte output.
// ----------------------------------------------------------------------------
module bfpcrc_back import bfpcrc_pkg::*; #(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  logic [MAX_FIELD_BITS-1:0] q_value,
  input  field_ctrl_t               q_ctrl,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                frame_byte,
  output logic                      last_byte,
  output back_status_t              status
);

  localparam int CW = $clog2(MAX_FIELD_BITS + 1);
  localparam int IW = $clog2(MAX_FIELD_BITS);

  back_state_t               state, state_next;
  logic [MAX_FIELD_BITS-1:0] val, val_next;
  logic [CW-1:0]             cnt, cnt_next;
  logic                      eof, eof_next;
  logic [3:0]                crc_cnt, crc_cnt_next;
  logic [7:0]                acc, acc_next;
  logic [2:0]                fill, fill_next;
  logic [15:0]               crc, crc_next;
  logic [7:0]                byte_q, byte_next;
  logic                      last_q, last_next;
  logic                      valid_q, valid_next;

  logic [CW-1:0] cnt_m1;
  logic          data_bit;
  logic [7:0]    packed_byte;
  logic          completes;
  logic          out_free;
  logic          adv;
  logic          load;

  assign cnt_m1      = cnt - 1'b1;
  assign out_free    = !valid_q || !out_stall;
  assign packed_byte = acc | (8'(data_bit) << (3'd7 - fill));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_ctrl.width != '0) begin
            state_next = ST_FIELD;
          end else if (q_ctrl.eof) begin
            state_next = ST_CRC;
          end
        end
      end
      ST_FIELD: begin
        if (adv && cnt == CW'(1)) begin
          state_next = eof ? ST_CRC : ST_IDLE;
        end
      end
      ST_CRC: begin
        if (adv && crc_cnt == 4'd0) begin
          state_next = completes ? ST_IDLE : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    val_next     = val;
    cnt_next     = cnt;
    eof_next     = eof;
    crc_cnt_next = crc_cnt;
    acc_next     = acc;
    fill_next    = fill;
    crc_next     = crc;
    data_bit     = 1'b0;
    completes    = 1'b0;
    adv          = 1'b0;
    q_pop        = 1'b0;
    byte_next    = packed_byte;
    last_next    = 1'b0;
    case (state)
      ST_IDLE: begin
        adv          = 1'b1;
        q_pop        = q_valid;
        crc_cnt_next = 4'd15;
        if (q_valid) begin
          val_next = q_value;
          cnt_next = CW'(q_ctrl.width);
          eof_next = q_ctrl.eof;
        end
      end
      ST_FIELD: begin
        data_bit  = val[cnt_m1[IW-1:0]];
        completes = (fill == 3'd7);
        adv       = !completes || out_free;
        if (adv) begin
          crc_next  = crc_step(crc, data_bit);
          acc_next  = completes ? 8'h00 : packed_byte;
          fill_next = fill + 1'b1;
          cnt_next  = cnt_m1;
        end
      end
      ST_CRC: begin
        data_bit  = crc[crc_cnt];
        completes = (fill == 3'd7);
        adv       = !completes || out_free;
        last_next = (crc_cnt == 4'd0);
        if (adv) begin
          acc_next     = completes ? 8'h00 : packed_byte;
          fill_next    = fill + 1'b1;
          crc_cnt_next = crc_cnt - 1'b1;
          if (crc_cnt == 4'd0 && completes) begin
            crc_next = CRC_INIT;
          end
        end
      end
      ST_FLUSH: begin
        completes = 1'b1;
        adv       = out_free;
        byte_next = acc;
        last_next = 1'b1;
        if (adv) begin
          acc_next  = 8'h00;
          fill_next = 3'd0;
          crc_next  = CRC_INIT;
        end
      end
      default: begin
        adv = 1'b0;
      end
    endcase
    load       = adv && completes;
    valid_next = load || (valid_q && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      acc     <= 8'h00;
      fill    <= 3'd0;
      crc     <= CRC_INIT;
      valid_q <= 1'b0;
    end else begin
      state   <= state_next;
      acc     <= acc_next;
      fill    <= fill_next;
      crc     <= crc_next;
      valid_q <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    val     <= val_next;
    cnt     <= cnt_next;
    eof     <= eof_next;
    crc_cnt <= crc_cnt_next;
    if (load) begin
      byte_q <= byte_next;
      last_q <= last_next;
    end
  end

  assign out_valid  = valid_q;
  assign frame_byte = byte_q;
  assign last_byte  = last_q;

  assign status.state    = state;
  assign status.fill     = fill;
  assign status.crc_init = (crc == CRC_INIT);
  assign status.adv      = adv;
  assign status.load     = load;

endmodule

// ===== hdl/bit_field_packer_crc16.sv =====
// ----------------------------------------------------------------------------
// bit_field_packer_crc16
// Packs variable width fields MSB first into bytes with a trailing CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries field_value, field_width and
//   end_of_frame. Only the low field_width bits are packed, MSB first; a
//   width above MAX_FIELD_BITS is clamped. Output channel (out_valid /
//   out_stall) carries one frame_byte per transfer, first packed bit in
//   bit 7, with last_byte set on the final byte of a frame.
//   Throughput: one field bit per cycle in the bit-serial back end, while
//   a completed byte is not held up by out_stall. The engine takes each
//   field from the queue, then shifts out its bits; end of frame adds the
//   16 CRC bits and, when a partial byte is left, a flush of that byte.
//   A transfer lands in the two entry queue, is picked up once the back
//   end is idle, and each completed byte is loaded into the output
//   register as the engine takes the bit that fills it.
//   The front queue keeps taking transfers while the back end works;
//   in_stall rises only when both entries are full.
//   When the receiver stalls, hold the output byte; the engine keeps
//   packing until the next byte completes, then waits.
//   Reset clears the queue, the partial byte and sets the CRC to 0xFFFF.
// ----------------------------------------------------------------------------
module bit_field_packer_crc16 import bfpcrc_pkg::*; #(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [63:0]              field_value,
  input  logic [FIELD_WIDTH_W-1:0] field_width,
  input  logic                     end_of_frame,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               frame_byte,
  output logic                     last_byte
);

  logic                      q_valid;
  logic [MAX_FIELD_BITS-1:0] q_value;
  field_ctrl_t               q_ctrl;
  logic                      q_pop;
  back_status_t              status;

  // Front: accept, clamp the width, queue
  bfpcrc_front #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .field_value  (field_value),
    .field_width  (field_width),
    .end_of_frame (end_of_frame),
    .q_valid      (q_valid),
    .q_value      (q_value),
    .q_ctrl       (q_ctrl),
    .q_pop        (q_pop)
  );

  // Back: shift out bits, update the CRC, emit bytes
  bfpcrc_back #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_value    (q_value),
    .q_ctrl     (q_ctrl),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .status     (status)
  );

  // Never overwrite a byte the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(status.load && out_valid && out_stall))
    else $error("byte loaded over a stalled transfer");

  // Flush only runs with a partial byte pending
  a_flush_partial: assert property (@(posedge clk) disable iff (rst)
    (status.state == ST_FLUSH) |-> (status.fill != 3'd0))
    else $error("flush entered on a byte boundary");

  // After a flush the frame state is back at reset values
  a_flush_restart: assert property (@(posedge clk) disable iff (rst)
    (status.state == ST_FLUSH && status.adv) |=>
      (status.state == ST_IDLE && status.fill == 3'd0 && status.crc_init))
    else $error("frame state not restarted after flush");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bit_field_packer_crc16: a directed table of fields
// followed by random frames, with every output byte compared against an
// in-bench bit packer and CRC-16 model, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfpcrc_pkg::*;

  localparam int QUIET_LIMIT    = 3000;  // cycles with no transfer before giving up
  localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 120;   // tail after the last byte (> one 64 bit field + CRC)
  localparam int REPORT_LIMIT   = 10;

  // One byte as the output channel carries it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  // One row of stimulus; typed rows carry their bytes, byte k in bits [8k+7:8k]
  typedef struct packed {
    logic [63:0]              value;
    logic [FIELD_WIDTH_W-1:0] width;
    logic                     eof;
    logic                     typed;
    logic [3:0]               n_typed;
    logic [63:0]              typed_bytes;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [63:0]              field_value = '0;
  logic [FIELD_WIDTH_W-1:0] field_width = '0;
  logic                     end_of_frame = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [7:0]               frame_byte;
  logic                     last_byte;

  // Packer model state: partial byte, its fill count and the running CRC
  logic [7:0]  pk_acc;
  int          pk_fill;
  logic [15:0] pk_crc;

  out_byte_t   pending_bytes[$];
  stim_row_t   directed_rows[$];

  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        holdoff_toggle = 1'b0;
  logic        holdoff_seen = 1'b0;
  int          holdoff_left = 0;

  // --------------------------------------------------------------------------
  // Clock and device
  // --------------------------------------------------------------------------
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit_field_packer_crc16 #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS_DEF)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .field_value  (field_value),
    .field_width  (field_width),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte)
  );

  // --------------------------------------------------------------------------
  // Packer model
  // --------------------------------------------------------------------------
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic data_bit);
    logic [15:0] t;
    t = crc ^ {data_bit, 15'b0};
    if (t[15]) begin
      crc16_next = {t[14:0], 1'b0} ^ CRC_POLY;
    end else begin
      crc16_next = {t[14:0], 1'b0};
    end
  endfunction

  function automatic void packer_clear();
    pk_acc  = 8'h00;
    pk_fill = 0;
    pk_crc  = CRC_INIT;
  endfunction

  // Drop one bit into the partial byte, MSB first; queue the byte once full
  function automatic void pack_one_bit(input logic data_bit);
    out_byte_t nb;
    pk_acc[7 - pk_fill] = data_bit;
    pk_fill++;
    if (pk_fill == 8) begin
      nb.data = pk_acc;
      nb.last = 1'b0;
      pending_bytes.push_back(nb);
      pk_acc  = 8'h00;
      pk_fill = 0;
    end
  endfunction

  // Pack one field and, on end of frame, its CRC and flush byte
  function automatic void pack_field(input logic [63:0] value,
                                     input logic [FIELD_WIDTH_W-1:0] width,
                                     input logic eof);
    int          n;
    logic [15:0] crc_snap;
    out_byte_t   nb;
    n = (int'(width) > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : int'(width);
    for (int i = n - 1; i >= 0; i--) begin
      pk_crc = crc16_next(pk_crc, value[i]);
      pack_one_bit(value[i]);
    end
    if (eof) begin
      // CRC bits are packed but do not feed the CRC
      crc_snap = pk_crc;
      for (int i = 15; i >= 0; i--) begin
        pack_one_bit(crc_snap[i]);
      end
      if (pk_fill != 0) begin
        nb.data = pk_acc;
        nb.last = 1'b1;
        pending_bytes.push_back(nb);
      end else begin
        // frame ends on a byte boundary: flag the CRC byte just queued
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      end
      packer_clear();
    end
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endfunction

  function automatic void add_row(input logic [63:0] value, input int width, input logic eof,
                                  input logic typed, input int n_typed,
                                  input logic [63:0] typed_bytes);
    stim_row_t row;
    row.value       = value;
    row.width       = width[FIELD_WIDTH_W-1:0];
    row.eof         = eof;
    row.typed       = typed;
    row.n_typed     = n_typed[3:0];
    row.typed_bytes = typed_bytes;
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: offer one field, hold it until the transfer, then predict
  // --------------------------------------------------------------------------
  task automatic send_field(input stim_row_t row);
    int        base;
    out_byte_t nb;
    in_valid     <= 1'b1;
    field_value  <= row.value;
    field_width  <= row.width;
    end_of_frame <= row.eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer took place at this edge
    base = pending_bytes.size();
    pack_field(row.value, row.width, row.eof);
    if (row.typed) begin
      // replace the model's bytes with the ones written into the table
      while (pending_bytes.size() > base) void'(pending_bytes.pop_back());
      for (int k = 0; k < int'(row.n_typed); k++) begin
        nb.data = row.typed_bytes[8*k +: 8];
        nb.last = row.eof && (k == int'(row.n_typed) - 1);
        pending_bytes.push_back(nb);
      end
    end
    // at random, drop valid and idle the sender; otherwise keep valid high
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Pause the sender until every queued byte has come out
  task automatic wait_all_bytes();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Random frames: mostly well-formed runs of fields closed by end of frame,
  // with some frames cut short or run on, plus zero and oversized widths
  task automatic run_random_frames(input int n_items);
    stim_row_t row;
    int        left;
    int        frame_len;
    int        r;
    left = n_items;
    while (left > 0) begin
      frame_len = $urandom_range(1, 6);
      for (int f = 0; f < frame_len && left > 0; f++) begin
        row       = '0;
        row.value = {$urandom, $urandom};
        r         = $urandom_range(99);
        // keep most fields short so frames stay quick
        if (r < 5) begin
          row.width = '0;
        end else if (r < 10) begin
          row.width = FIELD_WIDTH_W'($urandom_range(65, 127));
        end else if (r < 25) begin
          row.width = FIELD_WIDTH_W'($urandom_range(17, 64));
        end else begin
          row.width = FIELD_WIDTH_W'($urandom_range(1, 16));
        end
        row.eof = (f == frame_len - 1);
        if ($urandom_range(99) < 8) begin
          row.eof = ~row.eof;
        end
        send_field(row);
        left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_toggle != holdoff_seen) begin
      holdoff_seen <= holdoff_toggle;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall    <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each output transfer with the oldest queued byte
  always @(posedge clk) begin
    out_byte_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last_byte %0b", frame_byte, last_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (frame_byte !== want.data) begin
          note_failure($sformatf("frame_byte expected %02h actual %02h",
                                 want.data, frame_byte));
        end
        if (last_byte !== want.last) begin
          note_failure($sformatf("last_byte expected %0b actual %0b (byte %02h)",
                                 want.last, last_byte, want.data));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles without any transfer on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    packer_clear();

    // Directed table. Typed rows start from reset and stay byte aligned.
    // zero width with end of frame right after reset: bare initial CRC
    add_row(64'h0, 0, 1'b1, 1'b1, 2, 64'hFFFF);
    // one aligned byte
    add_row(64'hA5, 8, 1'b0, 1'b1, 1, 64'hA5);
    // widest field, all ones
    add_row({64{1'b1}}, 64, 1'b0, 1'b1, 8, {64{1'b1}});
    // zero width without end of frame: nothing comes out
    add_row(64'h0, 0, 1'b0, 1'b1, 0, 64'h0);
    // largest width code saturates to 64 bits
    add_row({64{1'b1}}, 127, 1'b0, 1'b1, 8, {64{1'b1}});
    // widest field, all zeros
    add_row(64'h0, 64, 1'b0, 1'b1, 8, 64'h0);
    // rows below leave the byte boundary and go through the model
    add_row(64'h1, 1, 1'b0, 1'b0, 0, 64'h0);
    add_row(64'hFFFF_FFFF_FFFF_FFFE, 1, 1'b1, 1'b0, 0, 64'h0);  // junk above the width
    add_row(64'h5A, 8, 1'b1, 1'b0, 0, 64'h0);                   // frame ends on a boundary
    add_row(64'h5, 3, 1'b0, 1'b0, 0, 64'h0);
    add_row(64'h0123_4567_89AB_CDEF, 65, 1'b0, 1'b0, 0, 64'h0); // just above the maximum
    add_row(64'h0, 0, 1'b1, 1'b0, 0, 64'h0);                    // zero width closes frame
    add_row(64'h8000_0000_0000_0001, 64, 1'b1, 1'b0, 0, 64'h0);
    add_row(64'h7F, 7, 1'b0, 1'b0, 0, 64'h0);
    add_row(64'h0, 7, 1'b0, 1'b0, 0, 64'h0);
    add_row(64'h2, 2, 1'b1, 1'b0, 0, 64'h0);
    add_row(64'hDEAD_BEEF_CAFE_F00D, 100, 1'b1, 1'b0, 0, 64'h0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 63, 1'b0, 1'b0, 0, 64'h0);
    add_row(64'h5555_5555_5555_5555, 1, 1'b1, 1'b0, 0, 64'h0);

    // hold reset, then release it at an edge
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling on either side
    foreach (directed_rows[i]) begin
      send_field(directed_rows[i]);
    end
    wait_all_bytes();

    // no idling; hold the output off for a long stretch so the queue fills
    holdoff_toggle <= ~holdoff_toggle;
    run_random_frames(40);
    wait_all_bytes();

    // sender idle about half the time
    send_idle_pct = 48;
    recv_stall_pct <= 0;
    run_random_frames(37);
    wait_all_bytes();

    // receiver stalling about half the time
    send_idle_pct = 0;
    recv_stall_pct <= 48;
    run_random_frames(37);
    wait_all_bytes();

    // both sides idling
    send_idle_pct = 31;
    recv_stall_pct <= 31;
    run_random_frames(36);
    wait_all_bytes();

    // let any stray output show before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      note_failure($sformatf("%0d bytes never came out", pending_bytes.size()));
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
